/* rtl/fed_pkg.sv */
// ----------------------------------------------------------------------------
// fed_pkg
// Shared constants and types of the ESC telemetry frame decoder.
// ----------------------------------------------------------------------------
package fed_pkg;

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int COUNT_W   = 5;
	localparam int IDLE_W    = 16;
	localparam int ALPHA_W   = 7;
	localparam int PERIOD_W  = 16;
	localparam int RPM_W     = 34;
	localparam int DIVIDEND_W = 41;
	localparam int STEP_W    = 6;

	// Frame and arithmetic constants
	localparam logic [BYTE_W-1:0]     SYNC_BYTE  = 8'h9B;
	localparam logic [COUNT_W-1:0]    COUNT_MAX  = 5'd31;
	localparam logic [IDLE_W-1:0]     IDLE_MAX   = 16'hFFFF;
	localparam logic [ALPHA_W-1:0]    ALPHA_MAX  = 7'd100;
	localparam logic [DIVIDEND_W-1:0] RPM_NUM_Q8 = 41'd15360000000;
	localparam logic [PERIOD_W-1:0]   AVG_DIV    = 16'd100;
	localparam logic [STEP_W-1:0]     DIV_STEPS  = 6'd41;

	// Divide by 100 as a multiply by ceil(2^48 / 100), exact for sums below 2^41.
	// The 41-bit sum and 42-bit reciprocal are split into 21-bit halves.
	localparam int RCP_HALF   = 21;
	localparam int RCP_PROD_W = 42;
	localparam int RCP_SUM_W  = 84;
	localparam int AVG_SHIFT  = 48;
	localparam logic [RCP_PROD_W-1:0] AVG_RCP = 42'd2814749767107;

	// Register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RST    = 7'd100;
	localparam logic [IDLE_W-1:0]  FRAME_GAP_RST = 16'd2000;
	localparam logic [IDLE_W-1:0]  STALE_TO_RST  = 16'd50000;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam logic [1:0] REG_ALPHA     = 2'd0;
	localparam logic [1:0] REG_FRAME_GAP = 2'd1;
	localparam logic [1:0] REG_STALE_TO  = 2'd2;

	// Item classified by the front part, handed to the back part
	typedef struct packed {
		logic                good;
		logic                bad;
		logic                stale;
		logic [BYTE_W-1:0]   throttle;
		logic [BYTE_W-1:0]   pwm;
		logic [PERIOD_W-1:0] period;
	} fed_cmd_t;

	// Result of one item
	typedef struct packed {
		logic              stale;
		logic              bad;
		logic              good;
		logic [RPM_W-1:0]  rpm_q8;
		logic [BYTE_W-1:0] pwm_level;
		logic [BYTE_W-1:0] throttle;
	} fed_res_t;

endpackage

/* rtl/esc_telemetry_frame_decoder.sv */
// ----------------------------------------------------------------------------
// esc_telemetry_frame_decoder
// Frames ESC serial telemetry by inter-byte gap and reports throttle, pwm
// and smoothed rpm.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer per received byte (tuser = 0, byte in tdata)
//   or per microsecond tick (tuser = 1). Every input transfer yields exactly
//   one output transfer carrying throttle, pwm, smoothed rpm (Q8) and the
//   frame_good / frame_bad / stale flags in tuser.
//   Path: an item that does not complete a good frame passes through the
//   queue into the result register. An item that completes a good frame runs
//   the 41-step bit-serial division 60e6/period, then the weighted sum and the
//   reciprocal multiply (states RCP1 and RCP2) that divides it by 100.
//   Throughput: the front classifies one item per cycle into a four-entry
//   queue; items behind a good frame wait in that queue while the back part
//   computes, and s_axis_tready drops when the queue is full.
//   When the receiver stalls, the result waits in the output register and the
//   queue keeps filling until full.
//   Reset: tvalid low, no bytes gathered, idle count at the stale timeout
//   reset value, registers at alpha 100, gap 2000 us, stale timeout 50000 us.
//   Registers (APB, byte address 4*i): 0 alpha_percent, 1 frame_gap_us,
//   2 stale_timeout_us. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_decoder #(
	parameter int PACKET_LEN = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
	input  logic [0:0]                         s_axis_tuser,  // [0] mode
	// Output stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] throttle, [15:8] pwm_level, [49:16] rpm_q8, [55:50] zero
	output logic [55:0]                        m_axis_tdata,
	// [0] frame_good, [1] frame_bad, [2] stale
	output logic [2:0]                         m_axis_tuser,
	// Configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fed_pkg::ADDR_W-1:0]         paddr,
	input  logic [fed_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fed_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import fed_pkg::*;

	logic [ALPHA_W-1:0] alpha_q;
	logic [IDLE_W-1:0]  frame_gap_q;
	logic [IDLE_W-1:0]  stale_to_q;
	logic               cfg_wr;

	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_valid;
	fed_cmd_t           q_in;
	fed_cmd_t           q_out;
	fed_res_t           res;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_RST;
			frame_gap_q <= FRAME_GAP_RST;
			stale_to_q  <= STALE_TO_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ALPHA:     alpha_q     <= pwdata[ALPHA_W-1:0];
				REG_FRAME_GAP: frame_gap_q <= pwdata[IDLE_W-1:0];
				REG_STALE_TO:  stale_to_q  <= pwdata[IDLE_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ALPHA:     prdata = APB_DATA_W'(alpha_q);
			REG_FRAME_GAP: prdata = APB_DATA_W'(frame_gap_q);
			REG_STALE_TO:  prdata = APB_DATA_W'(stale_to_q);
			default:       prdata = '0;
		endcase
	end

	// Front: framing and classification
	fed_front #(
		.PACKET_LEN (PACKET_LEN)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_valid       (s_axis_tvalid),
		.s_ready       (s_axis_tready),
		.mode          (s_axis_tuser[0]),
		.rx_byte       (s_axis_tdata),
		.frame_gap     (frame_gap_q),
		.stale_timeout (stale_to_q),
		.q_push        (q_push),
		.q_data        (q_in),
		.q_full        (q_full)
	);

	// Command queue
	fed_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	// Back: rpm, average, result register
	fed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.alpha   (alpha_q),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (res)
	);

	// Output packing
	assign m_axis_tdata = {6'b0, res.rpm_q8, res.pwm_level, res.throttle};
	assign m_axis_tuser = {res.stale, res.bad, res.good};

	// A judged frame is either good or bad, never both
	a_good_bad_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("frame_good and frame_bad both set");

	// Stale results carry zeroed values
	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata[49:0] == '0))
		else $error("stale result with nonzero values");

	// With the queue full no further item is taken
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !s_axis_tready)
		else $error("input ready while queue full");

endmodule

/* rtl/fed_queue.sv */
// ----------------------------------------------------------------------------
// fed_queue
// Four-entry command queue between the framing front and the compute back.
// ----------------------------------------------------------------------------
module fed_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fed_pkg::fed_cmd_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output fed_pkg::fed_cmd_t pop_data
);
	import fed_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	fed_cmd_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full     = (count_q == (PTR_W+1)'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && valid) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/fed_front.sv */
// ----------------------------------------------------------------------------
// fed_front
// Gathers bytes, counts idle ticks and judges frames; emits one command per
// accepted item into the queue.
// ----------------------------------------------------------------------------
module fed_front #(
	parameter int PACKET_LEN = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_valid,
	output logic                        s_ready,
	input  logic                        mode,
	input  logic [fed_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [fed_pkg::IDLE_W-1:0]  frame_gap,
	input  logic [fed_pkg::IDLE_W-1:0]  stale_timeout,
	output logic                        q_push,
	output fed_pkg::fed_cmd_t           q_data,
	input  logic                        q_full
);
	import fed_pkg::*;

	localparam int IDX_W = $clog2(PACKET_LEN);

	logic [BYTE_W-1:0]  bytes_q [PACKET_LEN];
	logic [COUNT_W-1:0] byte_count_q;
	logic [IDLE_W-1:0]  idle_q;

	logic               accept;
	logic [IDLE_W-1:0]  idle_nx;
	logic [COUNT_W-1:0] count_nx;
	logic               judge;
	logic               frame_ok;
	logic               in_range;

	assign s_ready = !q_full;
	assign accept  = s_valid && s_ready;
	assign q_push  = accept;
	assign in_range = (byte_count_q < COUNT_W'(PACKET_LEN));

	// Classify the item
	always_comb begin
		if (mode) begin
			idle_nx = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
		end else begin
			idle_nx = '0;
		end
		judge = mode && (idle_nx > frame_gap) && (byte_count_q != '0);
		frame_ok = (byte_count_q == COUNT_W'(PACKET_LEN)) && (bytes_q[0] == SYNC_BYTE)
			&& (bytes_q[4] == '0) && (bytes_q[6] == '0);
		if (!mode) begin
			count_nx = (byte_count_q < COUNT_MAX) ? byte_count_q + 1'b1 : byte_count_q;
		end else if (judge) begin
			count_nx = '0;
		end else begin
			count_nx = byte_count_q;
		end
		q_data.good     = judge && frame_ok;
		q_data.bad      = judge && !frame_ok;
		q_data.stale    = (idle_nx > stale_timeout);
		q_data.throttle = bytes_q[5];
		q_data.pwm      = bytes_q[7];
		q_data.period   = {bytes_q[8], bytes_q[9]};
	end

	// Frame byte store
	always_ff @(posedge clk) begin
		if (accept && !mode && in_range) begin
			bytes_q[byte_count_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			idle_q       <= STALE_TO_RST;
		end else if (accept) begin
			byte_count_q <= count_nx;
			idle_q       <= idle_nx;
		end
	end

endmodule

/* rtl/fed_div.sv */
// ----------------------------------------------------------------------------
// fed_div
// Restoring divider, one quotient bit per cycle, 41-bit dividend by 16 bits.
// ----------------------------------------------------------------------------
module fed_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fed_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [fed_pkg::PERIOD_W-1:0]   divisor,
	output logic                           done,
	output logic [fed_pkg::DIVIDEND_W-1:0] quotient
);
	import fed_pkg::*;

	logic [DIVIDEND_W-1:0] quo_q;
	logic [PERIOD_W-1:0]   rem_q;
	logic [PERIOD_W-1:0]   dvs_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [PERIOD_W:0]     trial;
	logic [PERIOD_W:0]     diff;
	logic                  fits;

	// One restoring step
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	assign done     = done_q;
	assign quotient = quo_q;

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= DIV_STEPS;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

/* rtl/fed_back.sv */
// ----------------------------------------------------------------------------
// fed_back
// Carries out queued commands: rpm division, exponential average, stale
// clearing, and the registered result stage.
// ----------------------------------------------------------------------------
module fed_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  fed_pkg::fed_cmd_t            q_data,
	output logic                         q_pop,
	input  logic [fed_pkg::ALPHA_W-1:0]  alpha,
	output logic                         m_valid,
	input  logic                         m_ready,
	output fed_pkg::fed_res_t            m_res
);
	import fed_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_SUM  = 7'b0001000,
		ST_RCP1 = 7'b0010000,
		ST_RCP2 = 7'b0100000,
		ST_FIN  = 7'b1000000
	} fed_state_t;

	fed_state_t            state_q;
	fed_cmd_t              cmd_q;
	logic [BYTE_W-1:0]     thr_q;
	logic [BYTE_W-1:0]     pwm_q;
	logic [RPM_W-1:0]      rpm_q;
	logic [RPM_W-1:0]      fresh_q;
	logic [RPM_W-1:0]      avg_q;
	logic [DIVIDEND_W-1:0] prod_new_s1;
	logic [DIVIDEND_W-1:0] prod_old_s1;
	logic [DIVIDEND_W-1:0] sum_s2;
	logic [RCP_PROD_W-1:0] pp_ll_s3;
	logic [RCP_PROD_W-1:0] pp_lh_s3;
	logic [RCP_PROD_W-1:0] pp_hl_s3;
	logic [RCP_PROD_W-1:0] pp_hh_s3;
	logic                  m_valid_q;
	fed_res_t              m_res_q;

	logic                  out_free;
	logic                  fin;
	logic                  commit;
	fed_cmd_t              c_cmd;
	logic [BYTE_W-1:0]     c_thr;
	logic [BYTE_W-1:0]     c_pwm;
	logic [RPM_W-1:0]      c_rpm;
	logic [ALPHA_W-1:0]    a_eff;
	logic [RCP_SUM_W-1:0]  rcp_sum;
	logic                  div_start;
	logic [PERIOD_W-1:0]   div_divisor;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_quo;

	assign out_free = !m_valid_q || m_ready;
	assign fin      = (state_q == ST_FIN);
	assign q_pop    = (state_q == ST_IDLE) && q_valid && (q_data.good || out_free);
	assign commit   = out_free
		&& (fin || ((state_q == ST_IDLE) && q_valid && !q_data.good));
	assign a_eff    = (alpha > ALPHA_MAX) ? ALPHA_MAX : alpha;
	assign m_valid  = m_valid_q;
	assign m_res    = m_res_q;

	// Values committed to the latched state and the result register
	always_comb begin
		c_cmd = fin ? cmd_q : q_data;
		c_thr = fin ? cmd_q.throttle : thr_q;
		c_pwm = fin ? cmd_q.pwm : pwm_q;
		c_rpm = fin ? avg_q : rpm_q;
		if (c_cmd.stale) begin
			c_thr = '0;
			c_pwm = '0;
			c_rpm = '0;
		end
	end

	// Divider runs the rpm division only; zero period counts as one
	assign div_start   = (state_q == ST_IDLE) && q_valid && q_data.good;
	assign div_divisor = (q_data.period == '0) ? PERIOD_W'(1) : q_data.period;

	fed_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (RPM_NUM_Q8),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Partial products recombined; quotient by 100 starts at bit 48
	always_comb begin
		rcp_sum = (RCP_SUM_W'(pp_hh_s3) << (2 * RCP_HALF))
			+ (RCP_SUM_W'(pp_lh_s3) << RCP_HALF)
			+ (RCP_SUM_W'(pp_hl_s3) << RCP_HALF)
			+ RCP_SUM_W'(pp_ll_s3);
	end

	// Arithmetic datapath
	always_ff @(posedge clk) begin
		if (q_pop && q_data.good) begin
			cmd_q <= q_data;
		end
		if ((state_q == ST_DIV) && div_done) begin
			fresh_q <= div_quo[RPM_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_new_s1 <= DIVIDEND_W'(a_eff) * DIVIDEND_W'(fresh_q);
			prod_old_s1 <= DIVIDEND_W'(ALPHA_MAX - a_eff) * DIVIDEND_W'(rpm_q);
		end
		if (state_q == ST_SUM) begin
			sum_s2 <= prod_new_s1 + prod_old_s1;
		end
		if (state_q == ST_RCP1) begin
			pp_ll_s3 <= RCP_PROD_W'(sum_s2[RCP_HALF-1:0])
				* RCP_PROD_W'(AVG_RCP[RCP_HALF-1:0]);
			pp_lh_s3 <= RCP_PROD_W'(sum_s2[RCP_HALF-1:0])
				* RCP_PROD_W'(AVG_RCP[RCP_PROD_W-1:RCP_HALF]);
			pp_hl_s3 <= RCP_PROD_W'(sum_s2[DIVIDEND_W-1:RCP_HALF])
				* RCP_PROD_W'(AVG_RCP[RCP_HALF-1:0]);
			pp_hh_s3 <= RCP_PROD_W'(sum_s2[DIVIDEND_W-1:RCP_HALF])
				* RCP_PROD_W'(AVG_RCP[RCP_PROD_W-1:RCP_HALF]);
		end
		if (state_q == ST_RCP2) begin
			avg_q <= rcp_sum[AVG_SHIFT +: RPM_W];
		end
		if (commit) begin
			m_res_q.throttle  <= c_thr;
			m_res_q.pwm_level <= c_pwm;
			m_res_q.rpm_q8    <= c_rpm;
			m_res_q.good      <= c_cmd.good;
			m_res_q.bad       <= c_cmd.bad;
			m_res_q.stale     <= c_cmd.stale;
		end
	end

	// Sequencer, latched outputs and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			thr_q     <= '0;
			pwm_q     <= '0;
			rpm_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				thr_q     <= c_thr;
				pwm_q     <= c_pwm;
				rpm_q     <= c_rpm;
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_data.good) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_RCP1;
				ST_RCP1: state_q <= ST_RCP2;
				ST_RCP2: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
